// ===== design/hfc_pkg.sv =====
// Package: constants, types and hex helpers for the hex identifier checksum checker.
package hfc_pkg;

  // Identifier layout: data digits followed by four check digits
  localparam int DATA_HEX_CHARS = 32;
  localparam int CHECK_CHARS    = 4;
  localparam int TOTAL_CHARS    = DATA_HEX_CHARS + CHECK_CHARS;
  // Count saturates at TOTAL_CHARS + 1
  localparam int CNT_W          = $clog2(TOTAL_CHARS + 2);

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_LENGTH = 2'd1,
    FAULT_HEX    = 2'd2,
    FAULT_CHECK  = 2'd3
  } fault_t;

  // One character held in the input stage
  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
    logic       is_last;
  } stage_t;

  // Verdict for one identifier
  typedef struct packed {
    logic       uid_ok;
    fault_t     fault;
    logic [7:0] sum_first;
    logic [7:0] sum_second;
  } verdict_t;

  // Decoded hex digit: ok is low for a non-hex character
  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_dig_t;

  function automatic hex_dig_t hex_value(input logic [7:0] c);
    hex_dig_t r;
    r.ok  = 1'b1;
    r.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.nib = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.nib = 4'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] upper_hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

// ===== design/hfc_if.sv =====
// Interfaces: character input channel and verdict output channel.
interface hfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface hfc_out_if;
  import hfc_pkg::*;
  logic       valid;
  logic       ready;
  logic       uid_ok;
  logic [1:0] fault;
  logic [7:0] sum_first;
  logic [7:0] sum_second;

  modport source (output valid, output uid_ok, output fault, output sum_first,
                  output sum_second, input ready);
  modport sink   (input valid, input uid_ok, input fault, input sum_first,
                  input sum_second, output ready);
endinterface

// ===== design/hfc_in_stage.sv =====
// Input register: holds one accepted character until the check stage takes it.
module hfc_in_stage (
  input  logic           clk,
  input  logic           rst,
  hfc_in_if.sink         chars,
  input  logic           advance,
  output hfc_pkg::stage_t item
);
  import hfc_pkg::*;

  logic       valid;
  logic [7:0] char_code;
  logic       is_last;
  logic       take;

  // Accept whenever the register is empty or drains this cycle
  assign chars.ready = !valid || advance;
  assign take        = chars.valid && chars.ready;

  // Load a new item, or drop the one that moved on
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_code <= chars.char_code;
      is_last   <= chars.is_last;
    end
  end

  assign item = stage_t'{valid: valid, char_code: char_code, is_last: is_last};

endmodule

// ===== design/hfc_check.sv =====
// Check stage: running Fletcher sums, digit checks and the verdict of one identifier.
module hfc_check (
  input  logic             clk,
  input  logic             rst,
  input  hfc_pkg::stage_t  item,
  input  logic             advance,
  output hfc_pkg::verdict_t verdict
);
  import hfc_pkg::*;

  localparam logic [CNT_W-1:0] DATA_END  = CNT_W'(DATA_HEX_CHARS);
  localparam logic [CNT_W-1:0] TOTAL_END = CNT_W'(TOTAL_CHARS);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(TOTAL_CHARS + 1);

  logic [CNT_W-1:0] char_count, char_count_next;
  logic [7:0]       acc_first, acc_first_next;
  logic [7:0]       acc_second, acc_second_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic             bad_digit_seen, bad_digit_seen_next;
  logic             check_mismatch_seen, check_mismatch_seen_next;

  hex_dig_t         dig;
  logic [3:0]       data_nib;
  logic [7:0]       data_byte;
  logic [CNT_W-1:0] chk_idx;
  logic [7:0]       chk_val;
  logic [3:0]       chk_nib;
  logic             in_data;
  logic             in_check;
  fault_t           fault;

  assign dig       = hex_value(item.char_code);
  assign data_nib  = dig.ok ? dig.nib : 4'd0;
  assign data_byte = {high_nibble, data_nib};
  assign in_data   = char_count < DATA_END;
  assign in_check  = !in_data && (char_count < TOTAL_END);
  assign chk_idx   = char_count - DATA_END;
  assign chk_val   = chk_idx[1] ? acc_second : acc_first;
  assign chk_nib   = chk_idx[0] ? chk_val[3:0] : chk_val[7:4];

  // Update sums and flags for the current character
  always_comb begin
    char_count_next          = char_count;
    acc_first_next           = acc_first;
    acc_second_next          = acc_second;
    high_nibble_next         = high_nibble;
    bad_digit_seen_next      = bad_digit_seen;
    check_mismatch_seen_next = check_mismatch_seen;
    if (in_data) begin
      if (!dig.ok) begin
        bad_digit_seen_next = 1'b1;
      end
      if (!char_count[0]) begin
        high_nibble_next = data_nib;
      end else begin
        acc_first_next  = acc_first + data_byte;
        acc_second_next = acc_second + acc_first_next;
      end
    end else if (in_check) begin
      if (item.char_code != upper_hex_char(chk_nib)) begin
        check_mismatch_seen_next = 1'b1;
      end
    end
    if (char_count < CNT_MAX) begin
      char_count_next = char_count + CNT_W'(1);
    end
  end

  // Rank faults: length, then hex digit, then checksum
  always_comb begin
    if (char_count_next != TOTAL_END) begin
      fault = FAULT_LENGTH;
    end else if (bad_digit_seen_next) begin
      fault = FAULT_HEX;
    end else if (check_mismatch_seen_next) begin
      fault = FAULT_CHECK;
    end else begin
      fault = FAULT_NONE;
    end
  end

  assign verdict.uid_ok     = (fault == FAULT_NONE);
  assign verdict.fault      = fault;
  assign verdict.sum_first  = acc_first_next;
  assign verdict.sum_second = acc_second_next;

  // Advance state; clear it after the last character of a string
  always_ff @(posedge clk) begin
    if (rst || (advance && item.is_last)) begin
      char_count          <= '0;
      acc_first           <= '0;
      acc_second          <= '0;
      high_nibble         <= '0;
      bad_digit_seen      <= 1'b0;
      check_mismatch_seen <= 1'b0;
    end else if (advance) begin
      char_count          <= char_count_next;
      acc_first           <= acc_first_next;
      acc_second          <= acc_second_next;
      high_nibble         <= high_nibble_next;
      bad_digit_seen      <= bad_digit_seen_next;
      check_mismatch_seen <= check_mismatch_seen_next;
    end
  end

endmodule

// ===== design/hfc_out_stage.sv =====
// Result register: holds one verdict item until the sink takes it.
module hfc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hfc_pkg::verdict_t verdict,
  output logic              free,
  hfc_out_if.source         result
);
  import hfc_pkg::*;

  logic     valid;
  verdict_t held;

  assign free = !valid || result.ready;

  // Hold the item until taken; load only when free
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= verdict;
    end
  end

  assign result.valid      = valid;
  assign result.uid_ok     = held.uid_ok;
  assign result.fault      = held.fault;
  assign result.sum_first  = held.sum_first;
  assign result.sum_second = held.sum_second;

endmodule

// ===== design/hex_id_fletcher_check_top.sv =====
// A verdict enters the result register as its last character moves on (result reg free).
// One character per cycle unless stalled; one verdict per identifier, on its last character.
// Sums and checks live in one register bank updated in a single pass per character.
// A waiting verdict stalls the input only when another last character must retire.
// Reset (rst, synchronous, active high) clears the sums, flags, count and both valids.
module hex_id_fletcher_check_top (
  input  logic      clk,
  input  logic      rst,
  hfc_in_if.sink    chars,
  hfc_out_if.source verdicts
);
  import hfc_pkg::*;

  stage_t   item;
  verdict_t verdict;
  logic     out_free;
  logic     advance;

  // Move a character on unless its verdict finds the result register full
  assign advance = item.valid && (!item.is_last || out_free);

  hfc_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .advance (advance),
    .item    (item)
  );

  hfc_check u_check (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .verdict (verdict)
  );

  hfc_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && item.is_last),
    .verdict (verdict),
    .free    (out_free),
    .result  (verdicts)
  );

`ifndef SYNTHESIS
  // A retiring last character shows up as a verdict next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (advance && item.is_last) |=> verdicts.valid)
    else $error("last character did not produce a verdict");

  // ok and fault code agree
  a_ok_matches_fault: assert property (@(posedge clk) disable iff (rst)
    verdicts.valid |-> (verdicts.uid_ok == (verdicts.fault == FAULT_NONE)))
    else $error("uid_ok disagrees with fault code");

  // Input stalls only when a character is held
  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    !chars.ready |-> (item.valid && item.is_last && !out_free))
    else $error("input stalled without a blocked last character");

  // Nothing valid right after reset
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (!verdicts.valid && !item.valid))
    else $error("valid set right after reset");
`endif

endmodule

// ===== sim/hex_id_fletcher_check_top_test.sv =====
// Testbench for the hex identifier checker: random ID strings vs. a Fletcher-style predictor (mod-256 sums).
`timescale 1ns / 1ps

module hex_id_fletcher_check_top_test;
  import hfc_pkg::*;

  localparam int STALL_LIMIT = 3000;   // cycles with no item moving on either side
  localparam int LONG_HOLD   = 400;    // one long verdict back-pressure stretch
  localparam int CALM_TAIL   = 150;    // pending characters left when idling stops

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_item_t;

  typedef enum int {
    ID_GOOD,
    ID_BAD_DIGIT,
    ID_BAD_CHECK,
    ID_LOWER_CHECK,
    ID_BAD_BOTH,
    ID_SHORT,
    ID_LONG,
    ID_LONG_BAD,
    ID_NOISE
  } id_kind_t;

  logic clk;
  logic rst;

  hfc_in_if  chars_if ();
  hfc_out_if verdicts_if ();

  hex_id_fletcher_check_top DUT (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars_if),
    .verdicts (verdicts_if)
  );

  char_item_t  pending_chars[$];
  verdict_t    expected_verdicts[$];
  logic [7:0]  id_text[$];

  // Checksum predictor state
  int unsigned chars_seen;
  logic [7:0]  run_first;
  logic [7:0]  run_second;
  logic [3:0]  pair_high;
  logic        bad_digit;
  logic        bad_check;

  int          fail_count;
  int          verdicts_seen;
  int          quiet_cycles;
  logic        char_accepted;
  int          in_gap;
  int          in_idle_pct;
  int          in_cycle;
  int          out_gap;
  int          out_idle_pct;
  int          out_cycle;
  int          hold_left;
  logic        hold_done;
  verdict_t    want;

  // Returns {invalid, nibble}
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    return 5'b10000;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] nib, input logic lower);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (lower ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 45;
    endcase
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] dv;
    c  = 8'($urandom);
    dv = digit_value(c);
    while (!dv[4]) begin
      c  = 8'($urandom);
      dv = digit_value(c);
    end
    return c;
  endfunction

  // Advance the checksum state by one character; queue a verdict on the last one
  task automatic absorb_char(input logic [7:0] c, input logic last);
    logic [4:0]  dv;
    logic [3:0]  nib;
    logic [7:0]  sel;
    int unsigned idx;
    if (chars_seen < DATA_HEX_CHARS) begin
      dv  = digit_value(c);
      nib = dv[4] ? 4'd0 : dv[3:0];
      if (dv[4]) bad_digit = 1'b1;
      if (chars_seen % 2 == 0) begin
        pair_high = nib;
      end else begin
        run_first  = run_first + {pair_high, nib};
        run_second = run_second + run_first;
      end
    end else if (chars_seen < TOTAL_CHARS) begin
      idx = chars_seen - DATA_HEX_CHARS;
      sel = (idx < 2) ? run_first : run_second;
      nib = idx[0] ? sel[3:0] : sel[7:4];
      if (c != nibble_char(nib, 1'b0)) bad_check = 1'b1;
    end
    if (chars_seen < TOTAL_CHARS + 1) chars_seen++;
    if (last) begin
      if (chars_seen != TOTAL_CHARS) want.fault = FAULT_LENGTH;
      else if (bad_digit) want.fault = FAULT_HEX;
      else if (bad_check) want.fault = FAULT_CHECK;
      else want.fault = FAULT_NONE;
      want.uid_ok     = (want.fault == FAULT_NONE);
      want.sum_first  = run_first;
      want.sum_second = run_second;
      expected_verdicts = {expected_verdicts, want};
      chars_seen = 0;
      run_first  = '0;
      run_second = '0;
      pair_high  = '0;
      bad_digit  = 1'b0;
      bad_check  = 1'b0;
    end
  endtask

  // Build one identifier string in id_text; fill < 0 means random data bytes
  task automatic make_id(input id_kind_t kind, input int fill);
    logic [7:0] b;
    logic [7:0] a1;
    logic [7:0] a2;
    logic       lower_check;
    int         n;
    int         pos;
    id_text.delete();
    a1 = '0;
    a2 = '0;
    lower_check = (kind == ID_LOWER_CHECK);
    for (int i = 0; i < DATA_HEX_CHARS / 2; i++) begin
      b  = (fill < 0) ? 8'($urandom) : 8'(fill);
      a1 = a1 + b;
      a2 = a2 + a1;
      id_text = {id_text, nibble_char(b[7:4], 1'($urandom_range(0, 1)))};
      id_text = {id_text, nibble_char(b[3:0], 1'($urandom_range(0, 1)))};
    end
    id_text = {id_text, nibble_char(a1[7:4], lower_check)};
    id_text = {id_text, nibble_char(a1[3:0], lower_check)};
    id_text = {id_text, nibble_char(a2[7:4], lower_check)};
    id_text = {id_text, nibble_char(a2[3:0], lower_check)};
    if (kind == ID_BAD_DIGIT || kind == ID_BAD_BOTH || kind == ID_LONG_BAD) begin
      pos = $urandom_range(0, DATA_HEX_CHARS - 1);
      id_text[pos] = non_hex_char();
    end
    if (kind == ID_BAD_CHECK || kind == ID_BAD_BOTH) begin
      pos = DATA_HEX_CHARS + $urandom_range(0, 3);
      id_text[pos] = id_text[pos] ^ 8'($urandom_range(1, 255));
    end
    case (kind)
      ID_SHORT: begin
        n = $urandom_range(1, TOTAL_CHARS - 1);
        while (id_text.size() > n) void'(id_text.pop_back());
      end
      ID_LONG, ID_LONG_BAD: begin
        n = $urandom_range(1, 40);
        repeat (n) id_text = {id_text, 8'($urandom)};
      end
      ID_NOISE: begin
        id_text.delete();
        n = $urandom_range(1, 45);
        repeat (n) id_text = {id_text, 8'($urandom)};
      end
      default: begin
      end
    endcase
  endtask

  // Queue id_text as characters, the final one marked last
  task automatic post_id();
    char_item_t it;
    for (int i = 0; i < id_text.size(); i++) begin
      it.code = id_text[i];
      it.last = (i == id_text.size() - 1);
      pending_chars = {pending_chars, it};
    end
  endtask

  task automatic queue_random_ids();
    int        rand_chars;
    int        roll;
    id_kind_t  kind;
    rand_chars = 0;
    while (rand_chars < 620) begin
      roll = $urandom_range(0, 99);
      if (roll < 58) kind = ID_GOOD;
      else if (roll < 66) kind = ID_BAD_DIGIT;
      else if (roll < 74) kind = ID_BAD_CHECK;
      else if (roll < 78) kind = ID_LOWER_CHECK;
      else if (roll < 81) kind = ID_BAD_BOTH;
      else if (roll < 88) kind = ID_SHORT;
      else if (roll < 93) kind = ID_LONG;
      else if (roll < 95) kind = ID_LONG_BAD;
      else kind = ID_NOISE;
      make_id(kind, -1);
      post_id();
      rand_chars += id_text.size();
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stimulus and end of run
  initial begin
    rst                    = 1'b1;
    chars_if.valid         = 1'b0;
    chars_if.char_code     = '0;
    chars_if.is_last       = 1'b0;
    verdicts_if.ready      = 1'b0;
    chars_seen    = 0;
    run_first     = '0;
    run_second    = '0;
    pair_high     = '0;
    bad_digit     = 1'b0;
    bad_check     = 1'b0;
    fail_count    = 0;
    verdicts_seen = 0;
    quiet_cycles  = 0;
    char_accepted = 1'b0;
    in_gap        = 0;
    in_idle_pct   = 0;
    in_cycle      = 0;
    out_gap       = 0;
    out_idle_pct  = 0;
    out_cycle     = 0;
    hold_left     = 0;
    hold_done     = 1'b0;

    // Directed: single-character strings at the code extremes
    id_text.delete(); id_text = {id_text, 8'h00}; post_id();
    id_text.delete(); id_text = {id_text, 8'hFF}; post_id();
    // Extreme data bytes, then the fault kinds
    make_id(ID_GOOD, 8'h00);        post_id();
    make_id(ID_GOOD, 8'hFF);        post_id();
    make_id(ID_GOOD, -1);           post_id();
    make_id(ID_BAD_DIGIT, -1);      post_id();
    make_id(ID_BAD_CHECK, -1);      post_id();
    make_id(ID_LOWER_CHECK, 8'hAB); post_id();
    make_id(ID_BAD_BOTH, -1);       post_id();
    make_id(ID_SHORT, -1);          post_id();
    make_id(ID_LONG_BAD, -1);       post_id();
    queue_random_ids();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Track character acceptance and predict
  always @(posedge clk) begin
    if (!rst && chars_if.valid && chars_if.ready) begin
      absorb_char(chars_if.char_code, chars_if.is_last);
      void'(pending_chars.pop_front());
      char_accepted <= 1'b1;
    end else begin
      char_accepted <= 1'b0;
    end
  end

  // Drive characters; hold an item until it is taken, idle in random bursts
  always @(negedge clk) begin
    in_cycle++;
    if (in_cycle % 128 == 0) in_idle_pct = pick_idle_pct();
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else if (!chars_if.valid || char_accepted) begin
      if (in_gap > 0) begin
        chars_if.valid <= 1'b0;
        in_gap--;
      end else if (pending_chars.size() == 0) begin
        chars_if.valid <= 1'b0;
      end else if (pending_chars.size() > CALM_TAIL &&
                   $urandom_range(0, 99) < in_idle_pct) begin
        chars_if.valid <= 1'b0;
        in_gap = $urandom_range(0, 13);
      end else begin
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= pending_chars[0].code;
        chars_if.is_last   <= pending_chars[0].last;
      end
    end
  end

  // Drive verdict ready: one long hold-off early, then random stall bursts
  always @(negedge clk) begin
    out_cycle++;
    if (out_cycle % 128 == 0) out_idle_pct = pick_idle_pct();
    if (!rst && !hold_done && verdicts_seen == 3) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (rst) begin
      verdicts_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      verdicts_if.ready <= 1'b0;
      hold_left--;
    end else if (out_gap > 0) begin
      verdicts_if.ready <= 1'b0;
      out_gap--;
    end else begin
      verdicts_if.ready <= 1'b1;
      if (pending_chars.size() > CALM_TAIL && $urandom_range(0, 99) < out_idle_pct)
        out_gap = $urandom_range(1, 14);
    end
  end

  // Check each verdict against the oldest prediction
  always @(posedge clk) begin
    if (!rst && verdicts_if.valid && verdicts_if.ready) begin
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        $error("verdict with none expected: uid_ok %0d fault %0d sums %02h %02h",
               verdicts_if.uid_ok, verdicts_if.fault, verdicts_if.sum_first,
               verdicts_if.sum_second);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (verdicts_if.uid_ok !== want.uid_ok) begin
          $error("uid_ok: expected %0d, got %0d", want.uid_ok, verdicts_if.uid_ok);
          fail_count++;
        end
        if (verdicts_if.fault !== want.fault) begin
          $error("fault: expected %0d, got %0d", want.fault, verdicts_if.fault);
          fail_count++;
        end
        if (verdicts_if.sum_first !== want.sum_first) begin
          $error("sum_first: expected %02h, got %02h", want.sum_first,
                 verdicts_if.sum_first);
          fail_count++;
        end
        if (verdicts_if.sum_second !== want.sum_second) begin
          $error("sum_second: expected %02h, got %02h", want.sum_second,
                 verdicts_if.sum_second);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((chars_if.valid && chars_if.ready) || (verdicts_if.valid && verdicts_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress, %0d characters and %0d verdicts outstanding",
                 pending_chars.size(), expected_verdicts.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
